/* rtl/core/dba_pkg.sv */
// Shared constants, codes and the table entry type for the disk block allocation table.
// No dependencies; every other file imports this package.
package dba_pkg;

	// Disk geometry
	localparam int NUM_BLOCKS  = 256;
	localparam int BLOCK_BYTES = 8;

	// Field widths of the request and response transfers
	localparam int CMD_W  = 2;
	localparam int ID_W   = 8;
	localparam int BC_W   = 12;
	localparam int BIX_W  = 8;
	localparam int ST_W   = 2;
	localparam int BCNT_W = 9;
	localparam int FB_W   = 8;

	// Derived internal widths
	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
	localparam int BC_MAX = 2**BC_W - 1;
	localparam int SUM_W  = $clog2(BC_MAX + BLOCK_BYTES);
	localparam int NEED_W = $clog2((BC_MAX + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);
	localparam int CMP_W  = (NEED_W > CNT_W) ? NEED_W : CNT_W;

	// Commands
	localparam logic [CMD_W-1:0] CMD_CREATE = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_REMOVE = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(2);

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = ST_W'(0);
	localparam logic [ST_W-1:0] ST_EXISTS   = ST_W'(1);
	localparam logic [ST_W-1:0] ST_NO_SPACE = ST_W'(2);
	localparam logic [ST_W-1:0] ST_BAD_ID   = ST_W'(3);

	// One block's entry in the table memory
	typedef struct packed {
		logic [ID_W-1:0]  owner;
		logic [BC_W-1:0]  bytes;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} entry_t;

endpackage

/* rtl/core/dba_if.sv */
// Request and response channel interfaces for the disk block allocation table.
// Depends on dba_pkg for field widths.

interface dba_req_if import dba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [ID_W-1:0]  file_id;
	logic [BC_W-1:0]  byte_count;
	logic [BIX_W-1:0] block_index;

	modport source (output valid, cmd, file_id, byte_count, block_index, input ready);
	modport sink   (input valid, cmd, file_id, byte_count, block_index, output ready);
endinterface

interface dba_rsp_if import dba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [BCNT_W-1:0] block_count;
	logic [FB_W-1:0]   first_block;
	logic [FB_W-1:0]   last_block;
	logic [ID_W-1:0]   owner_id;
	logic [BC_W-1:0]   file_bytes;

	modport source (output valid, status, block_count, first_block, last_block, owner_id,
		file_bytes, input ready);
	modport sink   (input valid, status, block_count, first_block, last_block, owner_id,
		file_bytes, output ready);
endinterface

/* rtl/core/disk_block_allocation_table.sv */
// Top level of the disk block allocation table: sequencer, table memory and valid bits.
// Depends on dba_pkg and the dba_req_if / dba_rsp_if interfaces.
//
//   channel | dir | payload                                                   | transfer
//   req     | in  | cmd, file_id, byte_count, block_index                     | valid & ready
//   rsp     | out | status, block_count, first_block, last_block, owner_id,   | valid & ready
//           |     | file_bytes                                                |
//
// Create: a sweep over all NUM_BLOCKS entries (existence, free count, span), then, for a new
//   id that needs blocks, if enough are free, an allocation sweep; both use the one read port.
// Remove: one sweep. Read: one table read if the index is in range. Id zero / unused cmd: none.
// Reset clears one valid bit per block at once; no clearing pass is needed.
// One request at a time; the next is taken while the previous response still waits.
// A stalled response holds the sequencer in its final state until the slot frees.

module disk_block_allocation_table import dba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dba_req_if.sink   req,
	dba_rsp_if.source rsp
);

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_ALLOC  = 3'd2;
	localparam logic [2:0] S_REMOVE = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  got_q;
	logic              exists_q;
	logic [ID_W-1:0]   id_q;
	logic [BC_W-1:0]   bytes_q;
	logic [NEED_W-1:0] need_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  last_q;

	// Result being built, and the response register
	logic [ST_W-1:0]   res_status_q;
	logic [BCNT_W-1:0] res_count_q;
	logic [FB_W-1:0]   res_first_q;
	logic [FB_W-1:0]   res_last_q;
	logic [ID_W-1:0]   res_owner_q;
	logic [BC_W-1:0]   res_bytes_q;
	logic              rsp_vld_q;
	logic [ST_W-1:0]   out_status_q;
	logic [BCNT_W-1:0] out_count_q;
	logic [FB_W-1:0]   out_first_q;
	logic [FB_W-1:0]   out_last_q;
	logic [ID_W-1:0]   out_owner_q;
	logic [BC_W-1:0]   out_bytes_q;

	// Table memory and read pipeline
	entry_t                mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] vld_q;
	entry_t                rd_data_s1;
	logic                  vbit_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic                  rd_vld_s1;

	logic              acc;
	logic              in_range;
	logic [SUM_W-1:0]  need_sum;
	logic [NEED_W-1:0] need_c;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              sweep_left;
	logic              sweep_end;
	logic [ID_W-1:0]   owner_s1;
	logic              hit_id;
	logic              hit_free;
	logic              wr_alloc;
	logic              wr_clear;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign in_range  = 32'(req.block_index) < NUM_BLOCKS;

	// Blocks needed: byte count rounded up to whole blocks
	assign need_sum = SUM_W'(req.byte_count) + SUM_W'(BLOCK_BYTES - 1);
	assign need_c   = NEED_W'(need_sum / SUM_W'(BLOCK_BYTES));

	// Sweep progress
	assign sweep_left = cnt_q < CNT_W'(NUM_BLOCKS);
	assign sweep_end  = !sweep_left && !rd_vld_s1;

	// Read port address selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (acc && req.cmd == CMD_READ && in_range) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(req.block_index);
				end
			end
			S_SCAN, S_ALLOC, S_REMOVE: begin
				rd_en = sweep_left;
			end
			default: ;
		endcase
	end

	// Entry returned by the memory; an invalid entry reads as free
	assign owner_s1 = vbit_s1 ? rd_data_s1.owner : '0;
	assign hit_id   = rd_vld_s1 && (owner_s1 == id_q);
	assign hit_free = rd_vld_s1 && (owner_s1 == '0);
	assign wr_alloc = (state_q == S_ALLOC) && hit_free && (CMP_W'(got_q) < CMP_W'(need_q));
	assign wr_clear = (state_q == S_REMOVE) && hit_id;

	// Table memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_alloc) begin
			mem[addr_s1] <= '{owner: id_q, bytes: bytes_q, first: first_q, last: last_q};
		end
		rd_data_s1 <= mem[rd_addr];
		vbit_s1    <= vld_q[rd_addr];
		addr_s1    <= rd_addr;
	end

	// Per-block valid bits, cleared by reset and by remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (wr_alloc) vld_q[addr_s1] <= 1'b1;
			if (wr_clear) vld_q[addr_s1] <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			free_q       <= '0;
			got_q        <= '0;
			exists_q     <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rsp_vld_q    <= 1'b0;
			id_q         <= '0;
			bytes_q      <= '0;
			need_q       <= '0;
			first_q      <= '0;
			last_q       <= '0;
			res_status_q <= ST_OK;
			res_count_q  <= '0;
			res_first_q  <= '0;
			res_last_q   <= '0;
			res_owner_q  <= '0;
			res_bytes_q  <= '0;
			out_status_q <= ST_OK;
			out_count_q  <= '0;
			out_first_q  <= '0;
			out_last_q   <= '0;
			out_owner_q  <= '0;
			out_bytes_q  <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en && state_q != S_IDLE) cnt_q <= cnt_q + CNT_W'(1);
			// S_FIN reloads the response register itself
			if (rsp.ready && state_q != S_FIN) rsp_vld_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						id_q         <= req.file_id;
						bytes_q      <= req.byte_count;
						need_q       <= need_c;
						cnt_q        <= '0;
						free_q       <= '0;
						got_q        <= '0;
						exists_q     <= 1'b0;
						res_status_q <= ((req.cmd == CMD_CREATE || req.cmd == CMD_REMOVE) &&
							req.file_id == '0) ? ST_BAD_ID : ST_OK;
						res_count_q  <= '0;
						res_first_q  <= '0;
						res_last_q   <= '0;
						res_owner_q  <= '0;
						res_bytes_q  <= '0;
						unique case (req.cmd)
							CMD_CREATE, CMD_REMOVE: begin
								if (req.file_id == '0) begin
									state_q <= S_FIN;
								end else if (req.cmd == CMD_CREATE) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_REMOVE;
								end
							end
							CMD_READ: state_q <= in_range ? S_READ : S_FIN;
							default:  state_q <= S_FIN;
						endcase
					end
				end

				// Existence, free count and span of the first N free blocks
				S_SCAN: begin
					if (hit_id) exists_q <= 1'b1;
					if (hit_free) begin
						if (free_q == '0) first_q <= addr_s1;
						if (CMP_W'(free_q) + CMP_W'(1) == CMP_W'(need_q)) last_q <= addr_s1;
						free_q <= free_q + CNT_W'(1);
					end
					if (sweep_end) begin
						priority if (exists_q) begin
							res_status_q <= ST_EXISTS;
							state_q      <= S_FIN;
						end else if (CMP_W'(free_q) < CMP_W'(need_q)) begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_FIN;
						end else if (need_q == '0) begin
							state_q <= S_FIN;
						end else begin
							res_count_q <= BCNT_W'(need_q);
							res_first_q <= FB_W'(first_q);
							res_last_q  <= FB_W'(last_q);
							cnt_q       <= '0;
							state_q     <= S_ALLOC;
						end
					end
				end

				// Claim free blocks in index order until N are taken
				S_ALLOC: begin
					if (wr_alloc) got_q <= got_q + CNT_W'(1);
					if (sweep_end) state_q <= S_FIN;
				end

				// Free every block of the id
				S_REMOVE: begin
					if (wr_clear) got_q <= got_q + CNT_W'(1);
					if (sweep_end) begin
						res_count_q <= BCNT_W'(got_q);
						state_q     <= S_FIN;
					end
				end

				S_READ: begin
					res_owner_q <= owner_s1;
					res_bytes_q <= vbit_s1 ? rd_data_s1.bytes : '0;
					res_first_q <= vbit_s1 ? FB_W'(rd_data_s1.first) : '0;
					res_last_q  <= vbit_s1 ? FB_W'(rd_data_s1.last) : '0;
					state_q     <= S_FIN;
				end

				// Hand the result to the response register once it is free
				S_FIN: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_count_q  <= res_count_q;
						out_first_q  <= res_first_q;
						out_last_q   <= res_last_q;
						out_owner_q  <= res_owner_q;
						out_bytes_q  <= res_bytes_q;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.block_count = out_count_q;
	assign rsp.first_block = out_first_q;
	assign rsp.last_block  = out_last_q;
	assign rsp.owner_id    = out_owner_q;
	assign rsp.file_bytes  = out_bytes_q;

	// Table writes happen only on returned read data of a sweep
	a_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_alloc || wr_clear) |-> rd_vld_s1 && (state_q == S_ALLOC || state_q == S_REMOVE))
		else $error("table write outside a sweep");

	// Allocation never claims more blocks than requested
	a_got_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> CMP_W'(got_q) <= CMP_W'(need_q))
		else $error("allocation exceeded requested block count");

	// Read data only returns while a command is consuming it
	a_rd_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q != S_IDLE && state_q != S_FIN))
		else $error("read data returned with no consumer");

	// A waiting response keeps the finished result parked
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && rsp_vld_q && !rsp.ready) |=> (state_q == S_FIN))
		else $error("result dropped while response stalled");

	// Free count stays within the disk
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) <= NUM_BLOCKS)
		else $error("free count overflow");

endmodule
